/* rtl/hsvrgb_pkg.sv */
// Package for the HSV to RGB pixel converter.
// Holds fixed-point constants, stage payload types and the hue decode helpers.
// No dependencies; used by every module of the converter.
package hsvrgb_pkg;

  // Fixed-point format of the inputs
  localparam int HUE_FRAC_BITS = 6;
  localparam int SAT_FRAC_BITS = 12;

  // Field widths
  localparam int HUE_W  = 15;
  localparam int SAT_W  = 13;
  localparam int LVL_W  = 8;
  localparam int CHAN_W = 8;

  // Hue units per 60 degree sector; it is 15 * 2^(HUE_FRAC_BITS + 2)
  localparam int HUE_UNIT = 60 << HUE_FRAC_BITS;
  // Saturation of one
  localparam int SAT_ONE  = 1 << SAT_FRAC_BITS;

  // Clamped saturation holds 0..SAT_ONE
  localparam int SATC_W = SAT_FRAC_BITS + 1;
  // Triangle weight t holds 0..HUE_UNIT
  localparam int T_W    = $clog2(HUE_UNIT + 1);
  // Weight sum (one-s)*U + s*t holds 0..SAT_ONE*HUE_UNIT
  localparam int W_W    = SAT_FRAC_BITS + T_W;
  // Level times weight sum, plus half the denominator
  localparam int N_W    = W_W + LVL_W + 1;
  // Level times (one - s)
  localparam int NM_W   = LVL_W + SATC_W;

  // Denominator SAT_ONE*HUE_UNIT = 15 * 2^DEN_SHIFT
  localparam int DEN_SHIFT = SAT_FRAC_BITS + HUE_FRAC_BITS + 2;
  // Scaled numerator before the divide by 15: at most 255*15 + 7
  localparam int M_W = $clog2(255 * 15 + 8);

  // Divide by 15 as multiply by reciprocal; exact for inputs below 23831
  localparam int DIV15_MUL = 17477;
  localparam int DIV15_SH  = 18;
  localparam int DIV15_W   = M_W + 15;

  // Largest multiple of two sectors that a hue can hold
  localparam int HUE_MAX  = (1 << HUE_W) - 1;
  localparam int PAIR_MAX = HUE_MAX / (2 * HUE_UNIT);
  localparam int SEC_LAST = 5;

  // Sector of the hue circle; names give the order of max/mid/min on R, G, B
  typedef enum logic [2:0] {
    SEC_RED_UP   = 3'd0,  // R=max G=mid B=min
    SEC_GRN_DN   = 3'd1,  // R=mid G=max B=min
    SEC_GRN_UP   = 3'd2,  // R=min G=max B=mid
    SEC_BLU_DN   = 3'd3,  // R=min G=mid B=max
    SEC_BLU_UP   = 3'd4,  // R=mid G=min B=max
    SEC_RED_DN   = 3'd5   // R=max G=min B=mid
  } sector_e;

  // Stage 1 to stage 2 payload
  typedef struct packed {
    logic [LVL_W-1:0]  lvl;
    logic [SATC_W-1:0] sat;
    logic [T_W-1:0]    tri_w;
    sector_e           sector;
  } dec_t;

  // Stage 2 to stage 3 payload
  typedef struct packed {
    logic [LVL_W-1:0] lvl;
    logic [W_W-1:0]   wsum;
    logic [NM_W-1:0]  nmin;
    sector_e          sector;
  } wgt_t;

  // Stage 3 to stage 4 payload
  typedef struct packed {
    logic [LVL_W-1:0]  lvl;
    logic [M_W-1:0]    mid_scaled;
    logic [CHAN_W-1:0] vmin;
    sector_e           sector;
  } scl_t;

  // Sector index: number of sector boundaries passed, capped at the last
  function automatic sector_e hue_sector(input logic [HUE_W-1:0] hue);
    logic [2:0] sec;
    sec = 3'd0;
    for (int k = 1; k <= SEC_LAST; k++) begin
      if (32'(hue) >= 32'(k * HUE_UNIT)) begin
        sec = 3'(k);
      end
    end
    return sector_e'(sec);
  endfunction

  // Triangle weight t = U - |(hue mod 2U) - U|
  function automatic logic [T_W-1:0] hue_triangle(input logic [HUE_W-1:0] hue);
    logic [31:0] base;
    logic [31:0] rem;
    base = 32'd0;
    for (int k = 1; k <= PAIR_MAX; k++) begin
      if (32'(hue) >= 32'(k * 2 * HUE_UNIT)) begin
        base = 32'(k * 2 * HUE_UNIT);
      end
    end
    rem = 32'(hue) - base;
    if (rem >= 32'(HUE_UNIT)) begin
      return T_W'(32'(2 * HUE_UNIT) - rem);
    end
    return T_W'(rem);
  endfunction

endpackage

/* rtl/hsvrgb_decode.sv */
// Stage 1 of the converter: saturation clamp, sector and triangle weight.
// Depends on hsvrgb_pkg.
module hsvrgb_decode (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  output logic                            ready_o,
  input  logic [hsvrgb_pkg::HUE_W-1:0]    hue_i,
  input  logic [hsvrgb_pkg::SAT_W-1:0]    saturation_i,
  input  logic [hsvrgb_pkg::LVL_W-1:0]    value_level_i,
  output logic                            valid_o,
  input  logic                            ready_i,
  output hsvrgb_pkg::dec_t                data_o
);
  import hsvrgb_pkg::*;

  logic valid_q;
  dec_t data_q, data_d;
  logic load;

  // Stage holds when full and downstream is stalled
  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  // Clamp saturation to one, decode hue
  always_comb begin
    data_d.lvl = value_level_i;
    if (32'(saturation_i) > 32'(SAT_ONE)) begin
      data_d.sat = SATC_W'(SAT_ONE);
    end else begin
      data_d.sat = SATC_W'(saturation_i);
    end
    data_d.tri_w  = hue_triangle(hue_i);
    data_d.sector = hue_sector(hue_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* rtl/hsvrgb_weight.sv */
// Stage 2 of the converter: weight sum (1-s)*U + s*t and level*(1-s).
// Depends on hsvrgb_pkg.
module hsvrgb_weight (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  hsvrgb_pkg::dec_t data_i,
  output logic             valid_o,
  input  logic             ready_i,
  output hsvrgb_pkg::wgt_t data_o
);
  import hsvrgb_pkg::*;

  logic              valid_q;
  wgt_t              data_q, data_d;
  logic              load;
  logic [SATC_W-1:0] comp;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  // Constant scale of (1-s) plus one small multiply s*t; level*(1-s) in parallel
  always_comb begin
    comp         = SATC_W'(SAT_ONE) - data_i.sat;
    data_d.lvl   = data_i.lvl;
    data_d.wsum  = W_W'(comp) * W_W'(HUE_UNIT) + W_W'(data_i.sat) * W_W'(data_i.tri_w);
    data_d.nmin  = NM_W'(data_i.lvl) * NM_W'(comp);
    data_d.sector = data_i.sector;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* rtl/hsvrgb_scale.sv */
// Stage 3 of the converter: level times weight sum, rounding offset, power-of-two
// part of the denominator; also rounds the min channel. Depends on hsvrgb_pkg.
module hsvrgb_scale (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  hsvrgb_pkg::wgt_t data_i,
  output logic             valid_o,
  input  logic             ready_i,
  output hsvrgb_pkg::scl_t data_o
);
  import hsvrgb_pkg::*;

  localparam logic [N_W-1:0]    HALF_DEN = N_W'(15) << (DEN_SHIFT - 1);
  localparam logic [NM_W:0]     HALF_ONE = (NM_W + 1)'(SAT_ONE / 2);

  logic            valid_q;
  scl_t            data_q, data_d;
  logic            load;
  logic [N_W-1:0]  num_mid;
  logic [NM_W:0]   num_min;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  // mid: (N + D/2) >> DEN_SHIFT, still to be divided by 15
  // min: denominator is a power of two, so round with a shift
  always_comb begin
    num_mid            = N_W'(data_i.lvl) * N_W'(data_i.wsum) + HALF_DEN;
    num_min            = (NM_W + 1)'(data_i.nmin) + HALF_ONE;
    data_d.lvl         = data_i.lvl;
    data_d.mid_scaled  = M_W'(num_mid >> DEN_SHIFT);
    data_d.vmin        = CHAN_W'(num_min >> SAT_FRAC_BITS);
    data_d.sector      = data_i.sector;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* rtl/hsvrgb_route.sv */
// Stage 4 of the converter: divide by 15, saturate, place max/mid/min on R, G, B.
// Output register of the block. Depends on hsvrgb_pkg.
module hsvrgb_route (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  output logic                                ready_o,
  input  hsvrgb_pkg::scl_t                    data_i,
  output logic                                valid_o,
  input  logic                                ready_i,
  output logic [hsvrgb_pkg::CHAN_W-1:0]       red_o,
  output logic [hsvrgb_pkg::CHAN_W-1:0]       green_o,
  output logic [hsvrgb_pkg::CHAN_W-1:0]       blue_o
);
  import hsvrgb_pkg::*;

  logic                 valid_q;
  logic                 load;
  logic [DIV15_W-1:0]   prod;
  logic [DIV15_W-1:0]   quot;
  logic [CHAN_W-1:0]    vmid;
  logic [CHAN_W-1:0]    red_d, green_d, blue_d;
  logic [CHAN_W-1:0]    red_q, green_q, blue_q;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  // Divide by 15 via reciprocal, then cap at full scale
  always_comb begin
    prod = DIV15_W'(data_i.mid_scaled) * DIV15_W'(DIV15_MUL);
    quot = prod >> DIV15_SH;
    if (quot > DIV15_W'(255)) begin
      vmid = 8'd255;
    end else begin
      vmid = CHAN_W'(quot);
    end
  end

  // Channel placement per sector
  always_comb begin
    case (data_i.sector)
      SEC_RED_UP: begin
        red_d = data_i.lvl;  green_d = vmid;        blue_d = data_i.vmin;
      end
      SEC_GRN_DN: begin
        red_d = vmid;        green_d = data_i.lvl;  blue_d = data_i.vmin;
      end
      SEC_GRN_UP: begin
        red_d = data_i.vmin; green_d = data_i.lvl;  blue_d = vmid;
      end
      SEC_BLU_DN: begin
        red_d = data_i.vmin; green_d = vmid;        blue_d = data_i.lvl;
      end
      SEC_BLU_UP: begin
        red_d = vmid;        green_d = data_i.vmin; blue_d = data_i.lvl;
      end
      default: begin
        red_d = data_i.lvl;  green_d = data_i.vmin; blue_d = vmid;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
    end
  end

  assign valid_o = valid_q;
  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;

  // The mid channel always lies between min and max
  a_mid_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> (vmid <= data_i.lvl) && (vmid >= data_i.vmin))
    else $error("mid channel outside min..max");

endmodule

/* rtl/hsv_to_rgb_pixel_converter_unit.sv */
// HSV to RGB pixel converter, top level.
// Depends on hsvrgb_pkg, hsvrgb_decode, hsvrgb_weight, hsvrgb_scale, hsvrgb_route.

// Converts one HSV pixel (hue in 1/64 degree, saturation in 1/4096, value as a
// 0..255 level) per clock, unless the output is held, into 8-bit RGB, rounded
// half up and saturated. The datapath is a four-stage pipeline (hue decode,
// weight multiply, level multiply, divide-by-15 and channel routing); a request
// passes the register of each stage in turn before it reaches the master side,
// and a new request can be taken every cycle unless the output is held.
// Each stage has its own valid bit and accepts new data when empty or when the
// next stage moves, so bubbles are squeezed out; s_axis_tready is a combinational
// chain from m_axis_tready through the four stages. Saturation above one is
// treated as one; hue of 300 degrees and above uses the last sector.
module hsv_to_rgb_pixel_converter_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // hue[14:0], saturation[27:15], value_level[35:28]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // red[7:0], green[15:8], blue[23:16]
);
  import hsvrgb_pkg::*;

  logic dec_valid, dec_ready;
  logic wgt_valid, wgt_ready;
  logic scl_valid, scl_ready;
  dec_t dec_data;
  wgt_t wgt_data;
  scl_t scl_data;
  logic [CHAN_W-1:0] red, green, blue;

  // Stage 1: hue decode
  hsvrgb_decode u_decode (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (s_axis_tvalid),
    .ready_o       (s_axis_tready),
    .hue_i         (s_axis_tdata[14:0]),
    .saturation_i  (s_axis_tdata[27:15]),
    .value_level_i (s_axis_tdata[35:28]),
    .valid_o       (dec_valid),
    .ready_i       (dec_ready),
    .data_o        (dec_data)
  );

  // Stage 2: weight sum
  hsvrgb_weight u_weight (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dec_valid),
    .ready_o (dec_ready),
    .data_i  (dec_data),
    .valid_o (wgt_valid),
    .ready_i (wgt_ready),
    .data_o  (wgt_data)
  );

  // Stage 3: level scaling
  hsvrgb_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (wgt_valid),
    .ready_o (wgt_ready),
    .data_i  (wgt_data),
    .valid_o (scl_valid),
    .ready_i (scl_ready),
    .data_o  (scl_data)
  );

  // Stage 4: final divide and channel routing
  hsvrgb_route u_route (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (scl_valid),
    .ready_o (scl_ready),
    .data_i  (scl_data),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .red_o   (red),
    .green_o (green),
    .blue_o  (blue)
  );

  assign m_axis_tdata = {blue, green, red};

  // Input stalls only when every stage is full and the output is held
  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> dec_valid && wgt_valid && scl_valid && m_axis_tvalid && !m_axis_tready)
    else $error("input stalled while pipeline has room");

  // A taken output always frees the input side
  a_take_frees_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready |-> s_axis_tready && scl_ready && wgt_ready && dec_ready)
    else $error("ready chain broken");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid && !dec_valid && !wgt_valid && !scl_valid)
    else $error("pipeline not empty in reset");

endmodule
